// ===== rtl/hrf_pkg.sv =====
// Shared types, codes and character constants of the HTTP request framer.
package hrf_pkg;

  // Message phase of the request being framed
  typedef enum logic [1:0] {
    PH_REQ  = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  // Position within one header line
  typedef enum logic [2:0] {
    HF_NAME   = 3'd0,
    HF_COLON  = 3'd1,
    HF_LEAD   = 3'd2,
    HF_DIGITS = 3'd3,
    HF_TAIL   = 3'd4,
    HF_BAD    = 3'd5,
    HF_NEG    = 3'd6
  } hfield_t;

  // Role of one byte
  typedef enum logic [3:0] {
    ROLE_CR     = 4'd0,
    ROLE_METHOD = 4'd1,
    ROLE_URI    = 4'd2,
    ROLE_TAIL   = 4'd3,
    ROLE_SEP    = 4'd4,
    ROLE_NAME   = 4'd5,
    ROLE_VALUE  = 4'd6,
    ROLE_LF     = 4'd7,
    ROLE_BODY   = 4'd8
  } role_t;

  // Event reported with one byte
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_REQ_OK   = 3'd1,
    EV_REQ_BAD  = 3'd2,
    EV_HDR_OK   = 3'd3,
    EV_HDR_BAD  = 3'd4,
    EV_LENGTH   = 3'd5,
    EV_BODY     = 3'd6,
    EV_COMPLETE = 3'd7
  } event_t;

  // Header line tracking state, minus the value accumulator
  typedef struct packed {
    hfield_t    field;
    logic [3:0] match_pos;
    logic       mismatch;
  } hdr_state_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] NAME_LEN = 4'd14;

  // Lower-case spelling of the length header name, one character per position
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Fold ASCII upper case to lower case
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

// ===== rtl/hrf_header.sv =====
// Header line byte tracker: name match, colon check and length value parse.
module hrf_header #(
  parameter int LENGTH_BITS = 31
) (
  input  logic [7:0]             c,
  input  hrf_pkg::hdr_state_t    cur,
  input  logic [LENGTH_BITS-1:0] acc,
  output hrf_pkg::hdr_state_t    nxt,
  output logic [LENGTH_BITS-1:0] acc_next,
  output hrf_pkg::role_t         role
);
  import hrf_pkg::*;

  logic                   digit;
  logic [3:0]             dval;
  logic [LENGTH_BITS+3:0] prod;
  logic [LENGTH_BITS-1:0] acc_sat;

  assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dval  = 4'(c - CH_ZERO);

  // Multiply by ten with shifts, add the digit, saturate at all ones
  assign prod    = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (LENGTH_BITS+4)'(dval);
  assign acc_sat = (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'b0) ? '1 : prod[LENGTH_BITS-1:0];

  // Advance the header line state by one byte
  always_comb begin
    nxt      = cur;
    acc_next = acc;
    role     = ROLE_VALUE;
    case (cur.field)
      HF_NAME: begin
        role = ROLE_NAME;
        if (c == CH_COLON) begin
          nxt.field = HF_COLON;
          role      = ROLE_SEP;
        end else if (cur.match_pos >= NAME_LEN ||
                     to_lower(c) != name_char(cur.match_pos)) begin
          nxt.mismatch = 1'b1;
        end else begin
          nxt.match_pos = cur.match_pos + 4'd1;
        end
      end
      HF_COLON: begin
        if (c == CH_SPACE) begin
          nxt.field = HF_LEAD;
          role      = ROLE_SEP;
        end else begin
          nxt.field = HF_BAD;
        end
      end
      HF_LEAD: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
          nxt.field = HF_LEAD;
        end else if (c == CH_PLUS) begin
          nxt.field = HF_DIGITS;
        end else if (c == CH_MINUS) begin
          nxt.field = HF_NEG;
        end else if (digit) begin
          nxt.field = HF_DIGITS;
          acc_next  = LENGTH_BITS'(dval);
        end else begin
          nxt.field = HF_TAIL;
        end
      end
      HF_DIGITS: begin
        if (digit) begin
          acc_next = acc_sat;
        end else begin
          nxt.field = HF_TAIL;
        end
      end
      default: begin
        role = ROLE_VALUE;
      end
    endcase
  end

endmodule

// ===== rtl/http_request_framer_unit.sv =====
// Top level of the HTTP request framer: byte classification and message framing.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) takes one raw request byte
//   per word. For every accepted byte the master channel gives exactly one
//   word: tdata holds the echoed byte and the committed content length,
//   tuser holds the byte's role and the event it raises (line well or badly
//   formed, length taken, body follows, request complete).
//   Output: the result of a byte is registered and on the master channel in the
//   cycle after the byte is accepted. Throughput: one byte per clock while
//   m_tready holds high; the figure is set by the single state update per
//   byte (phase, header name match, decimal length accumulate) between the
//   input and the result register.
//   Stall: while a result waits on m_tready low, s_tready falls and input
//   holds; s_tready follows m_tready in the same cycle, so a byte is taken
//   in the very cycle the pending result leaves.
//   Reset (rst, synchronous): s_tready is low, the block returns to the
//   start of a request line with zero length and body counters; no result
//   is pending.
module http_request_framer_unit #(
  parameter int LENGTH_BITS = 31
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_value
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((8+LENGTH_BITS+7)/8)*8-1:0] m_tdata,  // byte_echo, length_value, zero fill
  output logic [7:0] m_tuser    // [3:0] role, [6:4] event_res, zero fill
);
  import hrf_pkg::*;

  localparam int OUT_W = ((8 + LENGTH_BITS + 7) / 8) * 8;

  // Framing state
  phase_t                 phase;
  logic                   line_start;
  logic [1:0]             spaces_seen;
  hdr_state_t             hdr;
  logic [LENGTH_BITS-1:0] value_acc;
  logic [LENGTH_BITS-1:0] req_length;
  logic [LENGTH_BITS-1:0] body_count;

  phase_t                 phase_next;
  logic                   line_start_next;
  logic [1:0]             spaces_next;
  hdr_state_t             hdr_next;
  logic [LENGTH_BITS-1:0] value_acc_next;
  logic [LENGTH_BITS-1:0] req_length_next;
  logic [LENGTH_BITS-1:0] body_count_next;

  hdr_state_t             hdr_step;
  logic [LENGTH_BITS-1:0] acc_step;
  role_t                  hdr_role;

  role_t                  role;
  event_t                 ev;
  logic                   complete;
  logic                   take;
  logic [LENGTH_BITS-1:0] body_inc;
  logic [LENGTH_BITS-1:0] shown;
  logic [7:0]             c;

  localparam hdr_state_t HDR_CLEAR = '{field: HF_NAME, match_pos: 4'd0, mismatch: 1'b0};

  assign c        = s_tdata;
  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign take     = s_tvalid && s_tready;
  assign body_inc = body_count + LENGTH_BITS'(1);

  hrf_header #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_header (
    .c        (c),
    .cur      (hdr),
    .acc      (value_acc),
    .nxt      (hdr_step),
    .acc_next (acc_step),
    .role     (hdr_role)
  );

  // Classify the byte and work out the next framing state
  always_comb begin
    phase_next      = phase;
    spaces_next     = spaces_seen;
    hdr_next        = hdr;
    value_acc_next  = value_acc;
    req_length_next = req_length;
    body_count_next = body_count;
    role            = ROLE_CR;
    ev              = EV_NONE;
    complete        = 1'b0;
    case (phase)
      PH_BODY: begin
        role            = ROLE_BODY;
        body_count_next = body_inc;
        if (body_inc == req_length) begin
          complete = 1'b1;
          ev       = EV_COMPLETE;
        end
      end
      PH_HDR: begin
        if (c == CH_CR) begin
          role = ROLE_CR;
        end else if (c == CH_LF) begin
          role = ROLE_LF;
          if (line_start) begin
            if (req_length != '0) begin
              phase_next = PH_BODY;
              ev         = EV_BODY;
            end else begin
              complete = 1'b1;
              ev       = EV_COMPLETE;
            end
          end else if (!(hdr.field == HF_LEAD || hdr.field == HF_DIGITS ||
                         hdr.field == HF_TAIL || hdr.field == HF_NEG)) begin
            ev = EV_HDR_BAD;
          end else if (!hdr.mismatch && hdr.match_pos == NAME_LEN) begin
            req_length_next = (hdr.field == HF_NEG) ? '0 : value_acc;
            ev              = EV_LENGTH;
          end else begin
            ev = EV_HDR_OK;
          end
          spaces_next    = 2'd0;
          hdr_next       = HDR_CLEAR;
          value_acc_next = '0;
        end else begin
          role           = hdr_role;
          hdr_next       = hdr_step;
          value_acc_next = acc_step;
        end
      end
      default: begin
        // Request line; the unused phase code acts the same
        if (c == CH_CR) begin
          role = ROLE_CR;
        end else if (c == CH_LF) begin
          role           = ROLE_LF;
          ev             = (spaces_seen >= 2'd2) ? EV_REQ_OK : EV_REQ_BAD;
          phase_next     = PH_HDR;
          spaces_next    = 2'd0;
          hdr_next       = HDR_CLEAR;
          value_acc_next = '0;
        end else if (c == CH_SPACE && spaces_seen < 2'd2) begin
          role        = ROLE_SEP;
          spaces_next = spaces_seen + 2'd1;
        end else begin
          role = (spaces_seen == 2'd0) ? ROLE_METHOD :
                 (spaces_seen == 2'd1) ? ROLE_URI : ROLE_TAIL;
        end
      end
    endcase

    if (c == CH_LF) begin
      line_start_next = 1'b1;
    end else if (c != CH_CR) begin
      line_start_next = 1'b0;
    end else begin
      line_start_next = line_start;
    end

    // Report the length before a completed request clears it
    shown = req_length_next;
    if (complete) begin
      phase_next      = PH_REQ;
      req_length_next = '0;
      body_count_next = '0;
      spaces_next     = 2'd0;
      hdr_next        = HDR_CLEAR;
      value_acc_next  = '0;
    end
  end

  // Hold framing state, advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_REQ;
      line_start  <= 1'b0;
      spaces_seen <= 2'd0;
      hdr         <= HDR_CLEAR;
      value_acc   <= '0;
      req_length  <= '0;
      body_count  <= '0;
    end else if (take) begin
      phase       <= phase_next;
      line_start  <= line_start_next;
      spaces_seen <= spaces_next;
      hdr         <= hdr_next;
      value_acc   <= value_acc_next;
      req_length  <= req_length_next;
      body_count  <= body_count_next;
    end
  end

  // Result register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= OUT_W'({shown, c});
      m_tuser <= {1'b0, ev, role};
    end
  end

`ifndef NO_ASSERTIONS
  // A completed request leaves the framer at a clean request line
  a_complete_clears: assert property (@(posedge clk) disable iff (rst)
    (take && ev == EV_COMPLETE) |=>
      (phase == PH_REQ && req_length == '0 && body_count == '0))
    else $error("request complete did not clear framing state");

  // Inside the body the count stays below the committed length
  a_body_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (body_count < req_length))
    else $error("body count reached or passed content length");

  // A carriage return outside the body changes no framing state
  a_cr_no_effect: assert property (@(posedge clk) disable iff (rst)
    (take && c == CH_CR && phase != PH_BODY) |=>
      ($stable(phase) && $stable(line_start) && $stable(hdr) && $stable(spaces_seen)))
    else $error("dropped carriage return changed state");
`endif

endmodule
